>>> src/scalar_kalman_filter_defines.svh
// assertion macros for the scalar kalman filter
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SKF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/skf_pkg.sv
// shared types, constants and microcode program of the scalar kalman filter
`default_nettype none

package skf_pkg;

    // payload widths
    localparam int SAMPLE_W = 16;
    localparam int EST_W    = 16;
    localparam int GAIN_W   = 31;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 1'd1;

    // reset values, unsigned Q2.30
    localparam logic [31:0] MEAS_NOISE_RST = 32'd214748365;
    localparam logic [31:0] PROC_NOISE_RST = 32'd536871;
    localparam logic [31:0] COV_RST        = 32'd1073741824;

    // one in Q1.30 as a gain, and the rounding half
    localparam logic [GAIN_W-1:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [65:0]       HALF_Q30 = 66'h0_2000_0000;

    // divider: one quotient bit per step
    localparam int DIV_STEPS = 31;
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    // program counter
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;
    localparam t_pc PC_LAST = 4'd12;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_PRED,
        OP_DEN,
        OP_DIV,
        OP_MLO,
        OP_MHI,
        OP_MACC,
        OP_UPDX,
        OP_UPDP,
        OP_DONE
    } t_op;

    // multiplier operand pair
    typedef enum logic {
        SEL_EST,
        SEL_COV
    } t_sel;

    // jump conditions
    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_DENZ,
        JMP_LOOP
    } t_jmp;

    // one control word
    typedef struct packed {
        t_op  op;
        t_sel sel;
        t_jmp jmp;
        t_pc  target;
    } t_ctrl;

    // microcode program
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_NOP, sel: SEL_EST, jmp: JMP_NONE, target: '0};
        unique case (pc)
            4'd0:    w = '{op: OP_PRED, sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            4'd1:    w = '{op: OP_DEN,  sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            // zero denominator: skip the divide, gain stays zero
            4'd2:    w = '{op: OP_NOP,  sel: SEL_EST, jmp: JMP_DENZ, target: 4'd4};
            4'd3:    w = '{op: OP_DIV,  sel: SEL_EST, jmp: JMP_LOOP, target: 4'd3};
            // estimate update: acc = diff * gain + half
            4'd4:    w = '{op: OP_MLO,  sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            4'd5:    w = '{op: OP_MHI,  sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            4'd6:    w = '{op: OP_MACC, sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            4'd7:    w = '{op: OP_UPDX, sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            // covariance update: acc = pp * (one - gain) + half
            4'd8:    w = '{op: OP_MLO,  sel: SEL_COV, jmp: JMP_NONE, target: 4'd0};
            4'd9:    w = '{op: OP_MHI,  sel: SEL_COV, jmp: JMP_NONE, target: 4'd0};
            4'd10:   w = '{op: OP_MACC, sel: SEL_COV, jmp: JMP_NONE, target: 4'd0};
            4'd11:   w = '{op: OP_UPDP, sel: SEL_COV, jmp: JMP_NONE, target: 4'd0};
            4'd12:   w = '{op: OP_DONE, sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
            default: w = '{op: OP_NOP,  sel: SEL_EST, jmp: JMP_NONE, target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/skf_if.sv
// handshake interfaces for measurement, result and register write transactions
`default_nettype none

interface skf_in_if
    import skf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface skf_out_if
    import skf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [EST_W-1:0]  estimate;
    logic        [GAIN_W-1:0] gain;

    modport source (output valid, output estimate, output gain, input ready);
    modport sink   (input valid, input estimate, input gain, output ready);
endinterface

interface skf_cfg_if
    import skf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/scalar_kalman_filter.sv
// Scalar Kalman filter: a 16-bit measurement refines a Q16.16 estimate and a Q2.30
// covariance; each transaction returns the rounded estimate and the Q1.30 gain used.
// The gain comes from a restoring divider, one quotient bit per cycle, that is skipped
// when P+Q+R is zero; the other microcode steps run on one shared 34x17 multiplier.
// One item is in work at a time; the output register lets the next item be accepted
// while a result waits. Register writes are taken at any time but belong in idle periods.
`default_nettype none

module scalar_kalman_filter
    import skf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    skf_cfg_if.sink     i_cfg,
    skf_in_if.sink      i_in,
    skf_out_if.source   o_out
);

`include "scalar_kalman_filter_defines.svh"

    // control state
    logic        r_busy;
    t_pc         r_pc;
    t_pc         n_pc;
    logic [4:0]  r_cnt;
    logic        r_out_valid;

    // configuration and filter state
    logic [31:0] r_meas_noise;
    logic [31:0] r_proc_noise;
    logic signed [31:0] r_x;
    logic [31:0] r_p;

    // working registers
    logic signed [SAMPLE_W-1:0] r_z;
    logic [31:0] r_pp;
    logic [32:0] r_den;
    logic [32:0] r_diff;
    logic [32:0] r_rem;
    logic [GAIN_W-1:0] r_q;
    logic signed [50:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [EST_W-1:0] r_out_est;
    logic [GAIN_W-1:0] r_out_gain;

    t_ctrl ctrl;
    logic  in_fire;
    logic  out_free;
    logic  jump;

    // control word of the current step
    assign ctrl     = ucode(r_pc);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.estimate = r_out_est;
    assign o_out.gain     = r_out_gain;

    // jump condition and next step
    always_comb begin
        unique case (ctrl.jmp)
            JMP_DENZ: jump = (r_den == '0);
            JMP_LOOP: jump = (r_cnt != '0);
            default:  jump = 1'b0;
        endcase
        if (jump) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    // predict sum, saturated when loaded into r_pp
    logic [32:0] pred_sum;
    assign pred_sum = {1'b0, r_p} + {1'b0, r_proc_noise};

    // divider step
    logic        div_first;
    logic [33:0] div_tmp;
    logic        div_bit;
    assign div_first = (r_cnt == DIV_LAST);
    assign div_tmp   = div_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign div_bit   = (div_tmp >= {1'b0, r_den});

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic [GAIN_W-1:0]  mul_b_full;
    logic signed [16:0] mul_b;
    logic signed [50:0] mul_p;
    assign mul_a      = (ctrl.sel == SEL_COV) ? $signed({2'b00, r_pp})
                                              : $signed({r_diff[32], r_diff});
    assign mul_b_full = (ctrl.sel == SEL_COV) ? (ONE_Q30 - r_q) : r_q;
    assign mul_b      = (ctrl.op == OP_MHI) ? $signed({2'b00, mul_b_full[30:16]})
                                            : $signed({1'b0, mul_b_full[15:0]});
    assign mul_p      = mul_a * mul_b;

    // estimate update with clamp
    logic signed [36:0] x_sum;
    logic signed [31:0] x_new;
    assign x_sum = 37'(r_x) + 37'($signed(r_acc[65:30]));
    always_comb begin
        if (x_sum > 37'sd2147483647) begin
            x_new = 32'sh7FFF_FFFF;
        end else if (x_sum < -37'sd2147483648) begin
            x_new = 32'sh8000_0000;
        end else begin
            x_new = x_sum[31:0];
        end
    end

    // output rounding, ties toward +infinity, with clamp
    logic signed [32:0] est_sum;
    logic signed [16:0] est_sh;
    logic signed [EST_W-1:0] est_out;
    assign est_sum = 33'(r_x) + 33'sd32768;
    assign est_sh  = est_sum[32:16];
    always_comb begin
        if (est_sh > 17'sd32767) begin
            est_out = 16'sh7FFF;
        end else if (est_sh < -17'sd32768) begin
            est_out = 16'sh8000;
        end else begin
            est_out = est_sh[15:0];
        end
    end

    // sequencer, handshakes, registers and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pc         <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_meas_noise <= MEAS_NOISE_RST;
            r_proc_noise <= PROC_NOISE_RST;
            r_x          <= '0;
            r_p          <= COV_RST;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_MEAS_NOISE: r_meas_noise <= i_cfg.data;
                    REG_PROC_NOISE: r_proc_noise <= i_cfg.data;
                    default: ;
                endcase
            end
            // result register: load on completion, clear when taken
            if (r_busy && (ctrl.op == OP_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (!r_busy) begin
                if (in_fire) begin
                    r_busy <= 1'b1;
                    r_pc   <= '0;
                end
            end else if (ctrl.op == OP_DONE) begin
                if (out_free) begin
                    r_busy      <= 1'b0;
                    r_pc        <= '0;
                end
            end else begin
                r_pc <= n_pc;
                if (ctrl.op == OP_DEN) begin
                    r_cnt <= DIV_LAST;
                end else if (ctrl.op == OP_DIV) begin
                    r_cnt <= r_cnt - 5'd1;
                end
                if (ctrl.op == OP_UPDX) begin
                    r_x <= x_new;
                end
                if (ctrl.op == OP_UPDP) begin
                    r_p <= r_acc[61:30];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_z <= i_in.sample;
        end
        if (r_busy) begin
            case (ctrl.op)
                OP_PRED: begin
                    r_pp <= pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
                end
                OP_DEN: begin
                    r_den  <= {1'b0, r_pp} + {1'b0, r_meas_noise};
                    r_rem  <= {1'b0, r_pp};
                    r_q    <= '0;
                    r_diff <= {r_z[15], r_z, 16'h0000} - {r_x[31], r_x};
                end
                OP_DIV: begin
                    r_rem <= div_bit ? 33'(div_tmp - {1'b0, r_den}) : div_tmp[32:0];
                    r_q   <= {r_q[GAIN_W-2:0], div_bit};
                end
                OP_MLO: begin
                    r_prod <= mul_p;
                end
                OP_MHI: begin
                    r_acc  <= 66'(r_prod);
                    r_prod <= mul_p;
                end
                OP_MACC: begin
                    r_acc <= r_acc + (66'(r_prod) <<< 16) + $signed(HALF_Q30);
                end
                OP_DONE: begin
                    if (out_free) begin
                        r_out_est  <= est_out;
                        r_out_gain <= r_q;
                    end
                end
                default: ;
            endcase
        end
    end

    // checks
    `SKF_ASSERT_NOW(a_gain_max, i_clk, i_rst_n, o_out.valid, o_out.gain <= ONE_Q30,
        "gain above one")
    `SKF_ASSERT_NOW(a_pc_range, i_clk, i_rst_n, r_busy, r_pc <= PC_LAST,
        "step counter out of program")
    `SKF_ASSERT_NOW(a_denz_gain, i_clk, i_rst_n,
        r_busy && (ctrl.op == OP_MLO) && (r_den == '0), r_q == '0,
        "zero denominator with nonzero gain")
    `SKF_ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, in_fire, r_busy && (r_pc == '0),
        "accepted item did not start program")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the scalar kalman filter: directed and random measurements
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 60;
    localparam longint X_MAX = 64'sd2147483647;
    localparam longint X_MIN = -64'sd2147483648;

    // one filter output as the block should present it
    typedef struct {
        logic signed [EST_W-1:0]  estimate;
        logic        [GAIN_W-1:0] gain;
    } t_filter_out;

    // tracks the filter state and the outputs still owed by the block
    class kalman_predictor;
        logic        [CFG_DAT_W-1:0] meas_noise;
        logic        [CFG_DAT_W-1:0] proc_noise;
        logic signed [31:0]          est_q16;
        logic        [31:0]          cov_q30;
        t_filter_out                 owed_outputs[$];
        int mismatches;
        int results_seen;
        int samples_seen;
        int zero_den_steps;
        int saturated_steps;
        int unity_gain_steps;

        function new();
            meas_noise = MEAS_NOISE_RST;
            proc_noise = PROC_NOISE_RST;
            est_q16    = '0;
            cov_q30    = COV_RST;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DAT_W-1:0] value);
            if (index == REG_MEAS_NOISE) begin
                meas_noise = value;
            end else if (index == REG_PROC_NOISE) begin
                proc_noise = value;
            end
        endfunction

        function int pending();
            return owed_outputs.size();
        endfunction

        // one filter step for an accepted measurement
        function void note_sample(input logic signed [SAMPLE_W-1:0] z);
            longint unsigned pp;
            longint unsigned den;
            longint unsigned k;
            longint unsigned cov_next;
            longint          diff;
            longint          x;
            longint          rounded;
            t_filter_out     item;
            samples_seen++;
            // predict, saturating at the Q2.30 maximum
            pp = 64'(cov_q30) + 64'(proc_noise);
            if (pp > 64'hFFFF_FFFF) begin
                pp = 64'hFFFF_FFFF;
                saturated_steps++;
            end
            // gain, zero when the denominator is zero
            den = pp + 64'(meas_noise);
            if (den == 0) begin
                k = 0;
                zero_den_steps++;
            end else begin
                k = (pp << 30) / den;
            end
            if (k > 64'(ONE_Q30)) k = 64'(ONE_Q30);
            if (k == 64'(ONE_Q30)) unity_gain_steps++;
            // estimate update, rounded to nearest with ties up
            diff = longint'(z) * 65536 - longint'(est_q16);
            x = longint'(est_q16) + ((diff * longint'(k) + 64'sd536870912) >>> 30);
            if (x > X_MAX) x = X_MAX;
            if (x < X_MIN) x = X_MIN;
            est_q16 = x[31:0];
            // covariance update
            cov_next = ((64'(ONE_Q30) - k) * pp + 64'd536870912) >> 30;
            if (cov_next > 64'hFFFF_FFFF) cov_next = 64'hFFFF_FFFF;
            cov_q30 = cov_next[31:0];
            // integer estimate
            rounded = (x + 32768) >>> 16;
            if (rounded > 32767) rounded = 32767;
            if (rounded < -32768) rounded = -32768;
            item.estimate = rounded[15:0];
            item.gain     = k[30:0];
            owed_outputs.push_back(item);
        endfunction

        task report(input string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        // compare one accepted result with the oldest owed output
        task check_result(input logic signed [EST_W-1:0] estimate,
                          input logic [GAIN_W-1:0] gain);
            t_filter_out want;
            results_seen++;
            if (owed_outputs.size() == 0) begin
                report($sformatf("result %0d (estimate %0d gain %0d) with nothing owed",
                                 results_seen, estimate, gain));
                return;
            end
            want = owed_outputs.pop_front();
            if (estimate !== want.estimate) begin
                report($sformatf("result %0d estimate %0d, want %0d",
                                 results_seen, estimate, want.estimate));
            end
            if (gain !== want.gain) begin
                report($sformatf("result %0d gain %0d, want %0d",
                                 results_seen, gain, want.gain));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle;
    int   recv_stall;
    int   quiet_cycles;
    int   config_writes;

    kalman_predictor predictor;

    skf_in_if  in_if();
    skf_out_if out_if();
    skf_cfg_if cfg_if();

    scalar_kalman_filter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side backpressure
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            predictor.check_result(out_if.estimate, out_if.gain);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one measurement transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] z);
        while ($urandom_range(0, 99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= z;
        do @(posedge i_clk); while (!in_if.ready);
        predictor.note_sample(z);
    endtask

    // stop sending and wait until every owed output has come back
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge i_clk);
    endtask

    // write both noise registers back to back
    task automatic set_noise(input logic [CFG_DAT_W-1:0] r, input logic [CFG_DAT_W-1:0] q);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_MEAS_NOISE;
        cfg_if.data  <= r;
        do @(posedge i_clk); while (!cfg_if.ready);
        predictor.write_reg(REG_MEAS_NOISE, r);
        cfg_if.index <= REG_PROC_NOISE;
        cfg_if.data  <= q;
        do @(posedge i_clk); while (!cfg_if.ready);
        predictor.write_reg(REG_PROC_NOISE, q);
        cfg_if.valid <= 1'b0;
        config_writes += 2;
    endtask

    // noise variance drawn from zero, max, small, near one, full range or reset value
    function automatic logic [CFG_DAT_W-1:0] pick_noise(input logic [CFG_DAT_W-1:0] usual);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 32'h000F_FFFF);
            3:       return $urandom_range(32'h0800_0000, 32'h8000_0000);
            4:       return $urandom;
            default: return usual;
        endcase
    endfunction

    // measurement: mostly noise around a level, some full range and extremes
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int center);
        int spread;
        int v;
        spread = 1 << $urandom_range(0, 12);
        case ($urandom_range(0, 19))
            0, 1, 2: return 16'($urandom);
            3:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: begin
                v = center + int'($urandom_range(0, 2 * spread)) - spread;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return v[15:0];
            end
        endcase
    endfunction

    initial begin
        int center;
        int phase;
        int n;
        predictor     = new();
        config_writes = 0;
        send_idle     = 0;
        recv_stall    = 0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_MEAS_NOISE;
        cfg_if.data   = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset noise values, field extremes
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd100);
        send_sample(-16'sd100);

        // no noise at all: unity gain, then a zero denominator
        wait_for_results();
        set_noise('0, '0);
        send_sample(16'sd1234);
        send_sample(-16'sd5000);
        send_sample(16'sd7);

        // maximum noise: predicted covariance saturates
        wait_for_results();
        set_noise('1, '1);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);

        // exact measurement with huge process noise
        wait_for_results();
        set_noise('0, '1);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);

        // huge measurement noise, no process noise
        wait_for_results();
        set_noise('1, '0);
        send_sample(16'sd5);
        send_sample(-16'sd5);

        // random phases, each with its own noise setting and one of four idle patterns
        for (phase = 0; phase < 8; phase++) begin
            wait_for_results();
            set_noise(pick_noise(MEAS_NOISE_RST), pick_noise(PROC_NOISE_RST));
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 54; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 54; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            center = int'($urandom_range(0, 65535)) - 32768;
            for (n = 0; n < 50; n++) begin
                // sender holds off until the block has drained
                if (phase == 5 && n == 25) wait_for_results();
                if ($urandom_range(0, 15) == 0) center = int'($urandom_range(0, 65535)) - 32768;
                send_sample(pick_sample(center));
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d measurements, %0d results, %0d register writes",
                 predictor.samples_seen, predictor.results_seen, config_writes);
        $display("zero-denominator steps %0d, saturated predictions %0d, unity-gain steps %0d",
                 predictor.zero_den_steps, predictor.saturated_steps,
                 predictor.unity_gain_steps);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
